// ===== rtl/core/ps2_scancode_to_ascii_top_macros.svh =====
// Assertion helpers used by the decoder request queue.
// Each macro expects i_clk and i_rst_n in the scope of use.
`ifndef PS2_SCANCODE_TO_ASCII_TOP_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define PS2A_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ps2a assertion failed");

// next-cycle implication
`define PS2A_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ps2a assertion failed");

`endif

// ===== rtl/core/ps2a_pkg.sv =====
`default_nettype none

package ps2a_pkg;

    localparam int unsigned CODE_W     = 8;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned QUEUE_DEPTH = 2;

    // scan codes with special meaning
    localparam logic [CODE_W-1:0] SC_ALT    = 8'h11;
    localparam logic [CODE_W-1:0] SC_LSHIFT = 8'h12;
    localparam logic [CODE_W-1:0] SC_CTRL   = 8'h14;
    localparam logic [CODE_W-1:0] SC_CAPS   = 8'h58;
    localparam logic [CODE_W-1:0] SC_RSHIFT = 8'h59;
    localparam logic [CODE_W-1:0] SC_NUM    = 8'h77;
    localparam logic [CODE_W-1:0] SC_BREAK  = 8'hf0;
    localparam logic [CODE_W-1:0] SC_EXT    = 8'he0;
    localparam logic [CODE_W-1:0] SC_PAUSE  = 8'he1;

    typedef enum logic [1:0] {
        TBL_PLAIN,
        TBL_SHIFT,
        TBL_CTRL
    } t_tbl;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        t_tbl              sel;
    } t_req;

    // entries identical in the plain and shift tables
    function automatic logic [CHAR_W-1:0] common_lut(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'h0d: ch = 7'h09;
            7'h29: ch = 7'h20;
            7'h5a: ch = 7'h0a;
            7'h66: ch = 7'h08;
            7'h69: ch = 7'h31;
            7'h6b: ch = 7'h34;
            7'h6c: ch = 7'h37;
            7'h70: ch = 7'h30;
            7'h71: ch = 7'h2e;
            7'h72: ch = 7'h32;
            7'h73: ch = 7'h35;
            7'h74: ch = 7'h36;
            7'h75: ch = 7'h38;
            7'h76: ch = 7'h1b;
            7'h79: ch = 7'h2b;
            7'h7a: ch = 7'h33;
            7'h7b: ch = 7'h2d;
            7'h7c: ch = 7'h2a;
            7'h7d: ch = 7'h39;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] plain_lut(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'h0e: ch = 7'h60;
            7'h15: ch = 7'h71;
            7'h16: ch = 7'h31;
            7'h1a: ch = 7'h7a;
            7'h1b: ch = 7'h73;
            7'h1c: ch = 7'h61;
            7'h1d: ch = 7'h77;
            7'h1e: ch = 7'h32;
            7'h21: ch = 7'h63;
            7'h22: ch = 7'h78;
            7'h23: ch = 7'h64;
            7'h24: ch = 7'h65;
            7'h25: ch = 7'h34;
            7'h26: ch = 7'h33;
            7'h2a: ch = 7'h76;
            7'h2b: ch = 7'h66;
            7'h2c: ch = 7'h74;
            7'h2d: ch = 7'h72;
            7'h2e: ch = 7'h35;
            7'h31: ch = 7'h6e;
            7'h32: ch = 7'h62;
            7'h33: ch = 7'h68;
            7'h34: ch = 7'h67;
            7'h35: ch = 7'h79;
            7'h36: ch = 7'h36;
            7'h3a: ch = 7'h6d;
            7'h3b: ch = 7'h6a;
            7'h3c: ch = 7'h75;
            7'h3d: ch = 7'h37;
            7'h3e: ch = 7'h38;
            7'h41: ch = 7'h2c;
            7'h42: ch = 7'h6b;
            7'h43: ch = 7'h69;
            7'h44: ch = 7'h6f;
            7'h45: ch = 7'h30;
            7'h46: ch = 7'h39;
            7'h49: ch = 7'h2e;
            7'h4a: ch = 7'h2f;
            7'h4b: ch = 7'h6c;
            7'h4c: ch = 7'h3b;
            7'h4d: ch = 7'h70;
            7'h4e: ch = 7'h2d;
            7'h52: ch = 7'h27;
            7'h54: ch = 7'h5b;
            7'h55: ch = 7'h3d;
            7'h5b: ch = 7'h5d;
            7'h5d: ch = 7'h5c;
            default: ch = common_lut(code);
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] shift_lut(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'h0e: ch = 7'h7e;
            7'h15: ch = 7'h51;
            7'h16: ch = 7'h21;
            7'h1a: ch = 7'h5a;
            7'h1b: ch = 7'h53;
            7'h1c: ch = 7'h41;
            7'h1d: ch = 7'h57;
            7'h1e: ch = 7'h40;
            7'h21: ch = 7'h43;
            7'h22: ch = 7'h58;
            7'h23: ch = 7'h44;
            7'h24: ch = 7'h45;
            7'h25: ch = 7'h24;
            7'h26: ch = 7'h23;
            7'h2a: ch = 7'h56;
            7'h2b: ch = 7'h46;
            7'h2c: ch = 7'h54;
            7'h2d: ch = 7'h52;
            7'h2e: ch = 7'h25;
            7'h31: ch = 7'h4e;
            7'h32: ch = 7'h42;
            7'h33: ch = 7'h48;
            7'h34: ch = 7'h47;
            7'h35: ch = 7'h59;
            7'h36: ch = 7'h5e;
            7'h3a: ch = 7'h4d;
            7'h3b: ch = 7'h4a;
            7'h3c: ch = 7'h55;
            7'h3d: ch = 7'h26;
            7'h3e: ch = 7'h2a;
            7'h41: ch = 7'h3c;
            7'h42: ch = 7'h4b;
            7'h43: ch = 7'h49;
            7'h44: ch = 7'h4f;
            7'h45: ch = 7'h29;
            7'h46: ch = 7'h28;
            7'h49: ch = 7'h3e;
            7'h4a: ch = 7'h7c;
            7'h4b: ch = 7'h4c;
            7'h4c: ch = 7'h3a;
            7'h4d: ch = 7'h50;
            7'h4e: ch = 7'h5f;
            7'h52: ch = 7'h22;
            7'h54: ch = 7'h7b;
            7'h55: ch = 7'h2b;
            7'h5b: ch = 7'h7d;
            7'h5d: ch = 7'h7c;
            default: ch = common_lut(code);
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] ctrl_lut(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'h15: ch = 7'h11;
            7'h1a: ch = 7'h1a;
            7'h1b: ch = 7'h13;
            7'h1c: ch = 7'h01;
            7'h1d: ch = 7'h15;
            7'h21: ch = 7'h03;
            7'h22: ch = 7'h18;
            7'h23: ch = 7'h04;
            7'h24: ch = 7'h05;
            7'h2a: ch = 7'h16;
            7'h2b: ch = 7'h06;
            7'h2c: ch = 7'h14;
            7'h2d: ch = 7'h12;
            7'h31: ch = 7'h0e;
            7'h32: ch = 7'h02;
            7'h33: ch = 7'h08;
            7'h34: ch = 7'h07;
            7'h35: ch = 7'h19;
            7'h3a: ch = 7'h0d;
            7'h3b: ch = 7'h0a;
            7'h3c: ch = 7'h15;
            7'h42: ch = 7'h0b;
            7'h43: ch = 7'h09;
            7'h44: ch = 7'h0f;
            7'h4d: ch = 7'h10;
            7'h5a: ch = 7'h0d;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] ps2a_lookup(input t_req req);
        logic [CHAR_W-1:0] ch;
        case (req.sel)
            TBL_CTRL:  ch = ctrl_lut(req.code);
            TBL_SHIFT: ch = shift_lut(req.code);
            default:   ch = plain_lut(req.code);
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ps2a_front.sv =====
`default_nettype none

module ps2a_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ps2a_pkg::CODE_W-1:0] i_scan_code,
    input  logic                        i_q_ready,
    output logic                        o_ready,
    output logic                        o_push,
    output ps2a_pkg::t_req              o_req
);
    import ps2a_pkg::*;

    typedef enum logic [2:0] {
        PFX_IDLE,
        PFX_BREAK,
        PFX_EXT,
        PFX_EXTBRK,
        PFX_PAUSE
    } t_prefix_e;

    t_prefix_e r_state, n_state;
    logic      r_alt, n_alt;
    logic      r_ctrl, n_ctrl;
    logic      r_shift, n_shift;
    logic      r_lock, n_lock;
    logic      n_push;
    logic      accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        n_state = r_state;
        n_alt   = r_alt;
        n_ctrl  = r_ctrl;
        n_shift = r_shift;
        n_lock  = r_lock;
        n_push  = 1'b0;
        case (r_state)
            PFX_BREAK: begin
                if (i_scan_code == SC_ALT) begin
                    n_alt = 1'b0;
                end else if (i_scan_code == SC_CTRL) begin
                    n_ctrl = 1'b0;
                end else if (i_scan_code == SC_CAPS) begin
                    n_lock = 1'b0;
                end else if (i_scan_code == SC_LSHIFT || i_scan_code == SC_RSHIFT) begin
                    n_shift = 1'b0;
                end
                n_state = PFX_IDLE;
            end
            PFX_EXT: begin
                n_state = (i_scan_code == SC_BREAK) ? PFX_EXTBRK : PFX_IDLE;
            end
            PFX_EXTBRK: begin
                n_state = PFX_IDLE;
            end
            PFX_PAUSE: begin
                if (i_scan_code == SC_NUM) begin
                    n_state = PFX_IDLE;
                end
            end
            default: begin
                n_state = PFX_IDLE;
                if (i_scan_code == SC_ALT) begin
                    n_alt = 1'b1;
                end else if (i_scan_code == SC_CTRL) begin
                    n_ctrl = 1'b1;
                end else if (i_scan_code == SC_CAPS) begin
                    n_lock = 1'b1;
                end else if (i_scan_code == SC_NUM) begin
                    n_state = PFX_IDLE;
                end else if (i_scan_code == SC_LSHIFT || i_scan_code == SC_RSHIFT) begin
                    n_shift = 1'b1;
                end else if (i_scan_code == SC_BREAK) begin
                    n_state = PFX_BREAK;
                end else if (i_scan_code == SC_EXT) begin
                    n_state = PFX_EXT;
                end else if (i_scan_code == SC_PAUSE) begin
                    n_state = PFX_PAUSE;
                end else begin
                    // high codes and alt combos produce nothing
                    n_push = !i_scan_code[CODE_W-1] && !r_alt;
                end
            end
        endcase
    end

    always_comb begin
        o_req.code = i_scan_code[CHAR_W-1:0];
        if (r_ctrl) begin
            o_req.sel = TBL_CTRL;
        end else if (r_shift ^ r_lock) begin
            o_req.sel = TBL_SHIFT;
        end else begin
            o_req.sel = TBL_PLAIN;
        end
    end

    assign o_push = accept && n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PFX_IDLE;
            r_alt   <= 1'b0;
            r_ctrl  <= 1'b0;
            r_shift <= 1'b0;
            r_lock  <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_alt   <= n_alt;
            r_ctrl  <= n_ctrl;
            r_shift <= n_shift;
            r_lock  <= n_lock;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ps2a_queue.sv =====
`default_nettype none

`include "ps2_scancode_to_ascii_top_macros.svh"

module ps2a_queue #(
    parameter int unsigned DEPTH = ps2a_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ps2a_pkg::t_req i_req,
    output logic           o_ready,
    output logic           o_valid,
    output ps2a_pkg::t_req o_req,
    input  logic           i_pop
);
    import ps2a_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_req          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd];

    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `PS2A_ASSERT_IMP(a_no_overflow, i_push, (r_count != CW'(DEPTH)) || i_pop)
    `PS2A_ASSERT_IMP(a_no_underflow, i_pop, r_count != '0)
    `PS2A_ASSERT_NXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + CW'(1))

endmodule

`default_nettype wire

// ===== rtl/core/ps2a_back.sv =====
`default_nettype none

module ps2a_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ps2a_pkg::t_req              i_q_req,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [ps2a_pkg::CHAR_W-1:0] o_ascii_char,
    input  logic                        i_ready
);
    import ps2a_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] ch;
    logic              out_free;
    logic              load;

    assign ch       = ps2a_lookup(i_q_req);
    assign out_free = !r_valid || i_ready;
    // empty table entries are dropped without touching the output stage
    assign o_pop    = i_q_valid && ((ch == '0) || out_free);
    assign load     = i_q_valid && (ch != '0) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= ch;
        end
    end

    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;

endmodule

`default_nettype wire

// ===== rtl/core/ps2_scancode_to_ascii_top.sv =====
// Channel   Signals                           Transfer when
// -------   -------------------------------   ---------------------
// input     i_valid, o_ready, i_scan_code     i_valid && o_ready
// output    o_valid, i_ready, o_ascii_char    o_valid && i_ready
//
// One scan code per cycle is taken as long as the request queue has room.
// An accepted code is written into the request queue, and the character
// is registered in the output register before it transfers out; the table
// lookup sits between the queue head and the output register.
// Synchronous active-low reset clears prefix state, modifiers, queue and
// output valid. A stalled output backs up the queue; o_ready drops once
// the queue is full, so up to QUEUE_DEPTH + 1 characters can be in flight.
`default_nettype none

module ps2_scancode_to_ascii_top #(
    parameter int unsigned QUEUE_DEPTH = ps2a_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ps2a_pkg::CODE_W-1:0] i_scan_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ps2a_pkg::CHAR_W-1:0] o_ascii_char
);
    import ps2a_pkg::*;

    // front -> queue
    logic push;
    t_req push_req;
    logic q_ready;

    // queue -> back
    logic q_valid;
    t_req q_req;
    logic pop;

    // Front: prefix machine and modifier flags; only make codes that may
    // map to a character become lookup requests.
    ps2a_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_scan_code (i_scan_code),
        .i_q_ready   (q_ready),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_req       (push_req)
    );

    // Request queue decouples classification from lookup and output stall.
    ps2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (pop)
    );

    // Back: ROM lookup, zero entries dropped, result held in output register.
    ps2a_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_req      (q_req),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .i_ready      (i_ready)
    );

endmodule

`default_nettype wire
